[rtl/osrs_pkg.sv]
// ----------------------------------------------------------------------------
// osrs_pkg
// Shared widths, request and status codes, and the structs that pass between
// the ordered set controller and its row of key cells.
// ----------------------------------------------------------------------------
`default_nettype none

package osrs_pkg;

   localparam int KEY_W    = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EXISTS = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PREV   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_KTH    = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              eval;
      logic              ins;
      logic              del;
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  operand;
   } osrs_cmd_type;

   // what a cell shows to its two neighbors
   typedef struct packed {
      logic             occ;
      logic [KEY_W-1:0] key;
      logic             lt_now;
      logic             gt_now;
      logic             lt_reg;
   } osrs_nbr_type;

endpackage

`default_nettype wire

[rtl/osrs_cell.sv]
// ----------------------------------------------------------------------------
// osrs_cell
// One slot of the sorted key row. Compares its key with the broadcast operand,
// flags a selection for the query modes, and shifts keys with its neighbors
// on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module osrs_cell
   import osrs_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  osrs_cmd_type     cmd,
   input  osrs_nbr_type     left_nbr,
   input  osrs_nbr_type     right_nbr,
   output osrs_nbr_type     self_nbr,
   output logic             eq_out,
   output logic             hit_out,
   output logic [KEY_W-1:0] hit_key_out
);

   logic             occ_ff, occ_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             lt_ff, eq_ff, eq_in, hit_ff;
   logic [KEY_W-1:0] hit_key_ff, hit_key_in;
   logic             lt_now, gt_now, sel;

   always_comb begin
      lt_now = occ_ff && ($signed(key_ff) < $signed(cmd.operand));
      gt_now = occ_ff && ($signed(key_ff) > $signed(cmd.operand));
      eq_in  = occ_ff && (key_ff == cmd.operand);

      case (cmd.mode)
         MODE_NEXT: sel = gt_now && !left_nbr.gt_now;
         MODE_PREV: sel = lt_now && !right_nbr.lt_now;
         MODE_KTH:  sel = occ_ff && (cmd.operand == KEY_W'(INDEX));
         default:   sel = 1'b0;
      endcase
      hit_key_in = sel ? key_ff : '0;

      occ_in = occ_ff;
      key_in = key_ff;
      if (cmd.ins && !lt_ff) begin
         key_in = left_nbr.lt_reg ? cmd.operand : left_nbr.key;
         occ_in = occ_ff | left_nbr.occ;
      end else if (cmd.del && !lt_ff) begin
         key_in = right_nbr.key;
         occ_in = right_nbr.occ;
      end

      self_nbr.occ    = occ_ff;
      self_nbr.key    = key_ff;
      self_nbr.lt_now = lt_now;
      self_nbr.gt_now = gt_now;
      self_nbr.lt_reg = lt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         lt_ff  <= 1'b0;
         eq_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (cmd.eval) begin
            lt_ff  <= lt_now;
            eq_ff  <= eq_in;
            hit_ff <= sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmd.eval) begin
         hit_key_ff <= hit_key_in;
      end
   end

   assign eq_out      = eq_ff;
   assign hit_out     = hit_ff;
   assign hit_key_out = hit_key_ff;

endmodule

`default_nettype wire

[rtl/ordered_set_rank_select.sv]
// ----------------------------------------------------------------------------
// ordered_set_rank_select
// Bounded ordered set of distinct signed 32-bit keys with rank and neighbor
// queries, held sorted in a row of compare-and-shift cells.
//
// Request channel (req_valid/req_stall): req_mode selects insert, delete,
// exists, next, prev or kth; req_operand is the key, or the rank for kth.
// Response channel (rsp_valid/rsp_stall): exactly one transaction per
// request, rsp_status and rsp_key_out, in request order.
// A request is accepted, every cell compares its key with the operand in the
// next cycle, and in the commit state that follows the flags are reduced, the
// keys are shifted and the response register is loaded once the response slot
// is free. A new request is accepted in the commit cycle of the one before it,
// so the pace is set by the compare stage followed by the commit stage of the
// cell row.
// Reset empties the set and drops any pending response.
// While the receiver stalls, the response holds; a finished request then
// waits in its commit stage and req_stall stays high until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_set_rank_select
   import osrs_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic        [MODE_W-1:0]   req_mode,
   input  logic signed [KEY_W-1:0]    req_operand,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [KEY_W-1:0]    rsp_key_out
);

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_COMMIT} state_type;

   state_type               state_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [KEY_W-1:0]        operand_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [KEY_W-1:0]        rsp_key_ff;

   osrs_cmd_type            cmd;
   osrs_nbr_type            nbr       [CAPACITY];
   osrs_nbr_type            left_w    [CAPACITY];
   osrs_nbr_type            right_w   [CAPACITY];
   logic [CAPACITY-1:0]     eq_vec;
   logic [CAPACITY-1:0]     hit_vec;
   logic [KEY_W-1:0]        hit_key   [CAPACITY];

   logic                    any_eq, any_hit, full;
   logic [KEY_W-1:0]        found_key;
   logic                    commit_go, req_accept;
   logic                    do_ins, do_del;
   logic [STATUS_W-1:0]     status_in;
   logic [KEY_W-1:0]        key_in;

   osrs_nbr_type            left_edge, right_edge;

   always_comb begin
      left_edge.occ     = 1'b1;
      left_edge.key     = '0;
      left_edge.lt_now  = 1'b1;
      left_edge.gt_now  = 1'b0;
      left_edge.lt_reg  = 1'b1;
      right_edge.occ    = 1'b0;
      right_edge.key    = '0;
      right_edge.lt_now = 1'b0;
      right_edge.gt_now = 1'b1;
      right_edge.lt_reg = 1'b0;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_w[i] = left_edge;
      end else begin : g_inner_l
         assign left_w[i] = nbr[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w[i] = right_edge;
      end else begin : g_inner_r
         assign right_w[i] = nbr[i+1];
      end

      osrs_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_nbr    (left_w[i]),
         .right_nbr   (right_w[i]),
         .self_nbr    (nbr[i]),
         .eq_out      (eq_vec[i]),
         .hit_out     (hit_vec[i]),
         .hit_key_out (hit_key[i])
      );
   end

   always_comb begin
      any_eq    = |eq_vec;
      any_hit   = |hit_vec;
      full      = nbr[CAPACITY-1].occ;
      found_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_key = found_key | hit_key[i];
      end
   end

   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      status_in = STATUS_NONE;
      key_in    = '0;
      case (mode_ff) inside
         MODE_INSERT: begin
            if (any_eq) begin
               status_in = STATUS_NONE;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_OK;
               do_ins    = 1'b1;
            end
         end
         MODE_DELETE: begin
            do_del    = any_eq;
            status_in = any_eq ? STATUS_OK : STATUS_NONE;
         end
         MODE_EXISTS: begin
            status_in = any_eq ? STATUS_OK : STATUS_NONE;
         end
         MODE_NEXT, MODE_PREV, MODE_KTH: begin
            status_in = any_hit ? STATUS_OK : STATUS_NONE;
            key_in    = found_key;
         end
         default: begin
            status_in = STATUS_NONE;
         end
      endcase
   end

   assign commit_go  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && commit_go));
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.ins     = (state_ff == ST_COMMIT) && commit_go && do_ins;
      cmd.del     = (state_ff == ST_COMMIT) && commit_go && do_del;
      cmd.mode    = mode_ff;
      cmd.operand = operand_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_COMMIT) && commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (commit_go) begin
                  state_ff <= req_accept ? ST_EVAL : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= req_mode;
         operand_ff <= req_operand;
      end
      if ((state_ff == ST_COMMIT) && commit_go) begin
         rsp_status_ff <= status_in;
         rsp_key_ff    <= key_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_key_out = rsp_key_ff;

   a_eq_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> $onehot0(hit_vec))
      else $error("more than one cell selected for a query");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COMMIT) && commit_go && (status_in == STATUS_FULL))
      |-> (full && (mode_ff == MODE_INSERT)))
      else $error("full status without a full store");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> nbr[0].occ)
      else $error("insert left the first cell empty");

   a_eval_commit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVAL) && !$past(reset)) |-> $past(req_accept))
      else $error("compare stage entered without an accepted transaction");

endmodule

`default_nettype wire

[test/ordered_set_rank_select_tb.sv]
// ----------------------------------------------------------------------------
// ordered_set_rank_select_tb
// Self-checking bench for the ordered set. A directed sequence covers the key
// and rank extremes, duplicates, misses and the unused modes. It is followed
// by random grow and shrink runs that fill the store to capacity and thin it
// out again, under four sender/receiver idling mixes. Each response is
// compared in order against a sorted-queue copy of the set.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import osrs_pkg::*;

typedef struct packed {
   logic        [STATUS_W-1:0] status;
   logic signed [KEY_W-1:0]    key;
} set_result_type;

class set_scoreboard;
   int             capacity = 64;
   int             keys[$];
   set_result_type expected[$];
   int             errors;
   int             rsp_count;

   task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
   endtask

   // first index holding a key >= v, or > v when strict
   function int bound(int v, bit strict);
      int i;
      i = 0;
      while (i < keys.size() && (strict ? keys[i] <= v : keys[i] < v)) i++;
      return i;
   endfunction

   function void note(logic [MODE_W-1:0] m, int v);
      set_result_type r;
      int             pos;
      r.status = STATUS_NONE;
      r.key    = '0;
      pos      = bound(v, 1'b0);
      case (m)
         MODE_INSERT: begin
            if (pos < keys.size() && keys[pos] == v) r.status = STATUS_NONE;
            else if (keys.size() >= capacity) r.status = STATUS_FULL;
            else begin
               keys.insert(pos, v);
               r.status = STATUS_OK;
            end
         end
         MODE_DELETE: begin
            if (pos < keys.size() && keys[pos] == v) begin
               keys.delete(pos);
               r.status = STATUS_OK;
            end
         end
         MODE_EXISTS: begin
            if (pos < keys.size() && keys[pos] == v) r.status = STATUS_OK;
         end
         MODE_NEXT: begin
            pos = bound(v, 1'b1);
            if (pos < keys.size()) begin
               r.status = STATUS_OK;
               r.key    = keys[pos];
            end
         end
         MODE_PREV: begin
            if (pos > 0) begin
               r.status = STATUS_OK;
               r.key    = keys[pos-1];
            end
         end
         MODE_KTH: begin
            if (v >= 0 && v < keys.size()) begin
               r.status = STATUS_OK;
               r.key    = keys[v];
            end
         end
         default: ;
      endcase
      expected.push_back(r);
   endfunction

   task check(logic [STATUS_W-1:0] s, logic signed [KEY_W-1:0] k);
      set_result_type want;
      rsp_count++;
      if (expected.size() == 0) begin
         report($sformatf("response %0d with nothing pending (status %0d key %0d)",
                          rsp_count, s, k));
         return;
      end
      want = expected.pop_front();
      if (s !== want.status)
         report($sformatf("response %0d status %0d, want %0d", rsp_count, s, want.status));
      if (k !== want.key)
         report($sformatf("response %0d key %0d, want %0d", rsp_count, k, want.key));
   endtask
endclass

module ordered_set_rank_select_tb;

   localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;
   localparam int KEY_MIN     = 32'sh8000_0000;
   localparam int KEY_MAX     = 32'sh7fff_ffff;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RUN_LEN     = 170;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic        [MODE_W-1:0]   req_mode    = MODE_EXISTS;
   logic signed [KEY_W-1:0]    req_operand = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [KEY_W-1:0]    rsp_key_out;

   set_scoreboard sb;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            cycles        = 0;

   ordered_set_rank_select DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ordered_set_rank_select_tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_status, rsp_key_out);
   end

   // called at a falling edge, returns at a falling edge
   task send_item(logic [MODE_W-1:0] m, int v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_operand <= v;
      do @(posedge clock); while (req_stall);
      sb.note(m, v);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int pick_key(int hit_pct);
      int n;
      int r;
      n = sb.keys.size();
      r = $urandom_range(99);
      if (n != 0 && r < hit_pct) return sb.keys[$urandom_range(n-1)];
      r = $urandom_range(99);
      if (n != 0 && r < 20)
         return sb.keys[$urandom_range(n-1)] + ($urandom_range(1) ? 1 : -1);
      if (r < 35) begin
         case ($urandom_range(5))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MIN + 1;
            3: return KEY_MAX - 1;
            4: return 0;
            default: return -1;
         endcase
      end
      if (r < 75) return int'($urandom_range(200)) - 100;
      return int'($urandom);
   endfunction

   function automatic int pick_rank();
      int n;
      int r;
      n = sb.keys.size();
      r = $urandom_range(99);
      if (r < 70) return int'($urandom_range(n));
      if (r < 82) return int'($urandom | 32'h8000_0000);
      if (r < 92) return int'($urandom_range(n + 40));
      return int'($urandom);
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(int ins_w, int del_w);
      int r;
      r = $urandom_range(99);
      if (r < ins_w) return MODE_INSERT;
      if (r < ins_w + del_w) return MODE_DELETE;
      r = $urandom_range(99);
      if (r < 22) return MODE_EXISTS;
      if (r < 44) return MODE_NEXT;
      if (r < 66) return MODE_PREV;
      if (r < 92) return MODE_KTH;
      if (r < 96) return MODE_UNUSED_A;
      return MODE_UNUSED_B;
   endfunction

   task send_random(int ins_w, int del_w, int ins_hit);
      logic [MODE_W-1:0] m;
      int                v;
      m = pick_mode(ins_w, del_w);
      if (m == MODE_KTH) v = pick_rank();
      else if (m == MODE_INSERT) v = pick_key(ins_hit);
      else v = pick_key(50);
      send_item(m, v);
   endtask

   initial begin
      sb = new;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(MODE_EXISTS, 0);
      send_item(MODE_INSERT, KEY_MIN);
      send_item(MODE_INSERT, KEY_MAX);
      send_item(MODE_INSERT, 0);
      send_item(MODE_INSERT, 0);
      send_item(MODE_EXISTS, KEY_MIN);
      send_item(MODE_EXISTS, 5);
      send_item(MODE_NEXT, KEY_MAX);
      send_item(MODE_NEXT, KEY_MIN);
      send_item(MODE_PREV, KEY_MIN);
      send_item(MODE_PREV, KEY_MAX);
      send_item(MODE_NEXT, 0);
      send_item(MODE_KTH, 0);
      send_item(MODE_KTH, 2);
      send_item(MODE_KTH, 3);
      send_item(MODE_KTH, -1);
      send_item(MODE_KTH, KEY_MAX);
      send_item(MODE_DELETE, 5);
      send_item(MODE_DELETE, 0);
      send_item(MODE_PREV, 1);
      send_item(MODE_UNUSED_A, -1);
      send_item(MODE_UNUSED_B, KEY_MAX);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         // grow to capacity and sit there, then shrink
         for (int i = 0; i < RUN_LEN; i++) send_random(60, 5, 10);
         for (int i = 0; i < RUN_LEN; i++) send_random(15, 60, 40);
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("ordered_set_rank_select_tb: clean");
      else $display("ordered_set_rank_select_tb: errors");
      $finish;
   end

endmodule

[sim.f]
rtl/osrs_pkg.sv
rtl/osrs_cell.sv
rtl/ordered_set_rank_select.sv
test/ordered_set_rank_select_tb.sv
